// ----- hw/rtl/pvbe_pkg.sv -----
// Shared constants and controller/datapath handshake types for the back-EMF estimator.
package pvbe_pkg;

  // Default converter sample width.
  localparam int SAMPLE_BITS_DEF = 12;

  // Field widths fixed by the result format.
  localparam int SPEED_W = 16;
  localparam int EMF_W   = 17;
  localparam int MAG_W   = 16;

  // Scale factor applied to the phase difference before division by the bus sample.
  localparam int GAIN_W = 16;
  localparam logic [GAIN_W-1:0] EMF_GAIN = 16'd37837;

  // Saturation limit is 2**QUOT_W, so an unsaturated quotient has QUOT_W bits.
  localparam int QUOT_W = 15;
  localparam logic [MAG_W-1:0] EMF_LIMIT = 16'h8000;

  // Largest difference for which two phases count as close.
  localparam int CLOSE_MAX = 4;

  // Divider step counter width.
  localparam int CNT_W = $clog2(QUOT_W);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the accepted transaction
    logic mul;       // classify the phases and form the scaled difference
    logic check;     // test for saturation and seed the divider
    logic div_step;  // one restoring division step
    logic write;     // update the held estimate and the output
  } pvbe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;  // nonzero speed and bus, and a phase test matched
    logic sat;       // quotient would reach the saturation limit
  } pvbe_sts_t;

endpackage

// ----- hw/rtl/pvbe_ifs.sv -----
// Valid/ready channel interfaces for the estimator's input and result transactions.
interface pvbe_in_if #(
  parameter int SAMPLE_BITS = pvbe_pkg::SAMPLE_BITS_DEF
);
  logic                               valid;
  logic                               ready;
  logic        [SAMPLE_BITS-1:0]      phase_a_sample;
  logic        [SAMPLE_BITS-1:0]      phase_b_sample;
  logic        [SAMPLE_BITS-1:0]      phase_c_sample;
  logic        [SAMPLE_BITS-1:0]      bus_sample;
  logic signed [pvbe_pkg::SPEED_W-1:0] speed;
  logic                               reverse_request;

  modport source (
    output valid, phase_a_sample, phase_b_sample, phase_c_sample, bus_sample, speed,
           reverse_request,
    input  ready
  );
  modport sink (
    input  valid, phase_a_sample, phase_b_sample, phase_c_sample, bus_sample, speed,
           reverse_request,
    output ready
  );
endinterface

interface pvbe_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [pvbe_pkg::EMF_W-1:0]  emf_signed;
  logic        [pvbe_pkg::MAG_W-1:0]  emf_magnitude;
  logic                               start_allowed;
  logic                               direction_reverse;

  modport source (
    output valid, emf_signed, emf_magnitude, start_allowed, direction_reverse,
    input  ready
  );
  modport sink (
    input  valid, emf_signed, emf_magnitude, start_allowed, direction_reverse,
    output ready
  );
endinterface

// ----- hw/rtl/pvbe_ctrl.sv -----
// Controller state machine that sequences capture, scaling, division and result write.
module pvbe_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  pvbe_pkg::pvbe_sts_t sts,
  output pvbe_pkg::pvbe_cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL   = 5'b00010,
    ST_CHECK = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_WRITE = 5'b10000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [pvbe_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      slot_free;
  logic                      div_last;

  // The output register can take a new result when empty or being drained.
  assign slot_free = !out_valid_r || out_ready;
  assign div_last  = (cnt_r == pvbe_pkg::CNT_W'(pvbe_pkg::QUOT_W - 1));
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state, commands and division step count.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        if (sts.need_div && !sts.sat) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_WRITE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (div_last) begin
          cnt_nxt   = '0;
          state_nxt = ST_WRITE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_WRITE: begin
        if (slot_free) begin
          cmd.write = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  // Output valid flag: set by a write, cleared when the transaction is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.write) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A write never overruns a result that has not been taken.
  a_write_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |-> (!out_valid_r || out_ready))
    else $error("result written over a pending transaction");

  // An accepted transaction always moves straight to the scaling step.
  a_accept_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_MUL))
    else $error("accepted transaction did not start scaling");

  // The step counter is idle outside the division.
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_DIV) |-> (cnt_r == '0))
    else $error("division counter running outside division");

  // The division starts only from the saturation check.
  a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_DIV) |-> ($past(state_r) == ST_CHECK))
    else $error("division entered from the wrong state");

endmodule

// ----- hw/rtl/pvbe_datapath.sv -----
// Datapath: phase classification, scaling multiply, restoring divider and held estimate.
module pvbe_datapath #(
  parameter int SAMPLE_BITS = pvbe_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pvbe_pkg::pvbe_cmd_t                 cmd,
  output pvbe_pkg::pvbe_sts_t                 sts,
  input  logic        [SAMPLE_BITS-1:0]       phase_a_sample,
  input  logic        [SAMPLE_BITS-1:0]       phase_b_sample,
  input  logic        [SAMPLE_BITS-1:0]       phase_c_sample,
  input  logic        [SAMPLE_BITS-1:0]       bus_sample,
  input  logic signed [pvbe_pkg::SPEED_W-1:0] speed,
  input  logic                                reverse_request,
  output logic signed [pvbe_pkg::EMF_W-1:0]   emf_signed,
  output logic        [pvbe_pkg::MAG_W-1:0]   emf_magnitude,
  output logic                                start_allowed,
  output logic                                direction_reverse
);

  localparam int PROD_W = SAMPLE_BITS + pvbe_pkg::GAIN_W;
  localparam int HI_W   = PROD_W - pvbe_pkg::QUOT_W;

  // Captured transaction.
  logic [SAMPLE_BITS-1:0] a_r, b_r, c_r, bus_r;
  logic                   spd_zero_r, req_r;

  // Classification and scaled difference.
  logic                   hit_r;
  logic [PROD_W-1:0]      prod_r;

  // Divider partial remainder and dividend/quotient shift register.
  logic [SAMPLE_BITS-1:0]          rem_r;
  logic [pvbe_pkg::QUOT_W-1:0]     low_r;

  // Held estimate, which is also the output payload.
  logic signed [pvbe_pkg::EMF_W-1:0] emf_signed_r, emf_signed_nxt;
  logic [pvbe_pkg::MAG_W-1:0]        emf_mag_r, emf_mag_nxt;
  logic                              start_r, start_nxt;
  logic                              rev_r, rev_nxt;

  logic                   bus_zero;
  logic                   close_ab, close_bc, close_ca;
  logic                   hit_nxt;
  logic [SAMPLE_BITS-1:0] diff;
  logic [HI_W-1:0]        prod_hi;
  logic [SAMPLE_BITS:0]   trial;
  logic [SAMPLE_BITS:0]   trial_sub;
  logic                   trial_ge;
  logic [pvbe_pkg::MAG_W-1:0] mag_sel;

  function automatic logic is_close(input logic [SAMPLE_BITS-1:0] x,
                                    input logic [SAMPLE_BITS-1:0] y);
    logic [SAMPLE_BITS-1:0] d;
    d = (x > y) ? (x - y) : (y - x);
    return d <= SAMPLE_BITS'(pvbe_pkg::CLOSE_MAX);
  endfunction

  assign bus_zero = (bus_r == '0);

  // Phase tests in the order a-b, b-c, c-a; the last match sets the difference.
  always_comb begin
    close_ab = is_close(a_r, b_r);
    close_bc = is_close(b_r, c_r);
    close_ca = is_close(c_r, a_r);
    hit_nxt  = 1'b0;
    diff     = '0;
    if (close_ab && (c_r > a_r)) begin
      diff    = c_r - a_r;
      hit_nxt = 1'b1;
    end
    if (close_bc && (a_r > b_r)) begin
      diff    = a_r - b_r;
      hit_nxt = 1'b1;
    end
    if (close_ca && (b_r > c_r)) begin
      diff    = b_r - c_r;
      hit_nxt = 1'b1;
    end
  end

  // The quotient saturates exactly when the upper product bits reach the bus sample.
  assign prod_hi      = prod_r[PROD_W-1:pvbe_pkg::QUOT_W];
  assign sts.sat      = (prod_hi >= HI_W'(bus_r));
  assign sts.need_div = hit_r && !spd_zero_r && !bus_zero;

  // One restoring division step.
  assign trial     = {rem_r, low_r[pvbe_pkg::QUOT_W-1]};
  assign trial_ge  = (trial >= {1'b0, bus_r});
  assign trial_sub = trial - {1'b0, bus_r};

  // Capture, scaling and division registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r        <= phase_a_sample;
      b_r        <= phase_b_sample;
      c_r        <= phase_c_sample;
      bus_r      <= bus_sample;
      spd_zero_r <= (speed == '0);
      req_r      <= reverse_request;
    end
    if (cmd.mul) begin
      hit_r  <= hit_nxt;
      prod_r <= PROD_W'(diff) * PROD_W'(pvbe_pkg::EMF_GAIN);
    end
    if (cmd.check) begin
      rem_r <= prod_hi[SAMPLE_BITS-1:0];
      low_r <= prod_r[pvbe_pkg::QUOT_W-1:0];
    end else if (cmd.div_step) begin
      rem_r <= trial_ge ? trial_sub[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
      low_r <= {low_r[pvbe_pkg::QUOT_W-2:0], trial_ge};
    end
  end

  // Result update from the case that applies to this transaction.
  always_comb begin
    emf_signed_nxt = emf_signed_r;
    emf_mag_nxt    = emf_mag_r;
    start_nxt      = start_r;
    rev_nxt        = rev_r;
    mag_sel        = sts.sat ? pvbe_pkg::EMF_LIMIT : pvbe_pkg::MAG_W'(low_r);
    if (spd_zero_r) begin
      rev_nxt        = req_r;
      start_nxt      = 1'b1;
      emf_signed_nxt = '0;
      emf_mag_nxt    = '0;
    end else if (bus_zero) begin
      start_nxt      = 1'b0;
      emf_signed_nxt = '0;
      emf_mag_nxt    = '0;
    end else if (hit_r) begin
      start_nxt   = !sts.sat;
      emf_mag_nxt = mag_sel;
      if (rev_r) begin
        emf_signed_nxt = pvbe_pkg::EMF_W'(0) - {1'b0, mag_sel};
      end else begin
        emf_signed_nxt = {1'b0, mag_sel};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emf_signed_r <= '0;
      emf_mag_r    <= '0;
      start_r      <= 1'b0;
      rev_r        <= 1'b0;
    end else if (cmd.write) begin
      emf_signed_r <= emf_signed_nxt;
      emf_mag_r    <= emf_mag_nxt;
      start_r      <= start_nxt;
      rev_r        <= rev_nxt;
    end
  end

  assign emf_signed        = emf_signed_r;
  assign emf_magnitude     = emf_mag_r;
  assign start_allowed     = start_r;
  assign direction_reverse = rev_r;

  // The divider only runs with a partial remainder below the divisor.
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (rem_r < bus_r))
    else $error("partial remainder out of range");

  // The magnitude never exceeds the saturation limit.
  a_mag_limit: assert property (@(posedge clk) disable iff (!rst_n)
    emf_mag_r <= pvbe_pkg::EMF_LIMIT)
    else $error("estimate magnitude above limit");

  // A saturated estimate always denies start.
  a_sat_start: assert property (@(posedge clk) disable iff (!rst_n)
    (emf_mag_r == pvbe_pkg::EMF_LIMIT) |-> !start_r)
    else $error("start allowed with saturated estimate");

endmodule

// ----- hw/rtl/phase_voltage_back_emf_estimator.sv -----
// Top level of the phase-voltage back-EMF estimator.
//
// One input transaction gives one result transaction. A transaction with a nonzero speed,
// a nonzero bus sample and a matching phase test whose estimate stays below 32768 passes
// through a capture step, a step for the phase tests and the scaling multiply, a
// saturation check, 15 steps of the restoring divider that form the 15-bit quotient,
// and a result write. Every other transaction skips the divider. The result sits in
// an output register that is also the held estimate, so the next transaction is
// accepted while the last result waits; a finished estimate waits in the write step
// only while the previous result has not been taken.
module phase_voltage_back_emf_estimator #(
  parameter int SAMPLE_BITS = pvbe_pkg::SAMPLE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  pvbe_in_if.sink      in_chan,
  pvbe_out_if.source   out_chan
);

  pvbe_pkg::pvbe_cmd_t cmd;
  pvbe_pkg::pvbe_sts_t sts;

  pvbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pvbe_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .phase_a_sample    (in_chan.phase_a_sample),
    .phase_b_sample    (in_chan.phase_b_sample),
    .phase_c_sample    (in_chan.phase_c_sample),
    .bus_sample        (in_chan.bus_sample),
    .speed             (in_chan.speed),
    .reverse_request   (in_chan.reverse_request),
    .emf_signed        (out_chan.emf_signed),
    .emf_magnitude     (out_chan.emf_magnitude),
    .start_allowed     (out_chan.start_allowed),
    .direction_reverse (out_chan.direction_reverse)
  );

endmodule
